/* sv/ryv_pkg.sv */
// Shared types, constants and the exp2 factor table for the viscosity pipeline.
package ryv_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned LOG_W     = 22;
   localparam int unsigned E_W       = 38;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned EXP_LANES = 2;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [31:0] Q_ONE     = 32'h0001_0000;
   localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

   // Exponent limits for exp2, signed Q.32
   localparam logic signed [63:0] EXP_LO = -(64'sd64 <<< 32);
   localparam logic signed [63:0] EXP_HI = 64'sd16 <<< 32;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CONSISTENCY_K       = 8'd0,
      REG_FLOW_INDEX_N        = 8'd1,
      REG_YIELD_STRESS        = 8'd2,
      REG_VISCOSITY_CAP       = 8'd3,
      REG_REGULARIZATION_RATE = 8'd4,
      REG_STRAIN_RATE_FLOOR   = 8'd5
   } reg_index_type;

   // Per-item data carried alongside the log2 and exp2 units
   typedef struct packed {
      logic [DATA_W-1:0] sr;
      logic [E_W-1:0]    e;
      logic              big;
   } side_type;

   // Bitwise integer square root (elaboration only)
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v   = v_in;
      res = '0;
      b   = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Factors 2^(2^-i), i = 1..16, Q2.30, entry i-1 at bits [32*(i-1) +: 32]
   function automatic logic [FRAC_W*32-1:0] fac_table();
      logic [63:0]            fac;
      logic [FRAC_W*32-1:0]   tab;
      fac = 64'h8000_0000;
      tab = '0;
      for (int i = 0; i < FRAC_W; i++) begin
         fac = isqrt64(fac << 30);
         tab[i*32 +: 32] = fac[31:0];
      end
      return tab;
   endfunction

   localparam logic [FRAC_W*32-1:0] EXP2_FAC = fac_table();

endpackage

/* sv/regularized_yield_viscosity.sv */
// Top level: regularised Herschel-Bulkley viscosity pipeline with register port.
//
//  Channel  Direction  Ports                              Contents
//  req      in         req_tvalid/tready/tdata[31:0]      strain_rate Q16.16
//  rsp      out        rsp_tvalid/tready/tdata[31:0]      viscosity Q16.16
//  csr      in         csr_valid/ready/index[7:0]/data    register writes
//
// One item enters per cycle while rsp is not stalled; each result passes through the
// log2 with 16 squaring stages, the exp2 with 16 factor stages and the divider with 32 step stages.
// Reset clears all valid bits and restores the register defaults.
// A result held on rsp stalls the whole pipeline and req_tready drops with it.
module regularized_yield_viscosity (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] strain_rate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] viscosity
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ryv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import ryv_pkg::*;

   logic adv;

   // Configuration registers
   logic [31:0] k_ff, n_ff, tau_ff, cap_ff, m_ff, floor_ff;

   // Front stages
   logic        v1_ff, v2_ff;
   logic [31:0] sr1_ff;
   logic [63:0] xprod1_ff;
   side_type    side2_ff;
   logic [47:0] x_in;
   logic [51:0] eprod_in;

   // log2 output and exponent stage
   logic                    lg_valid;
   logic signed [LOG_W-1:0] lg_log;
   side_type                lg_side;
   logic                    vt_ff;
   side_type                sidet_ff;
   logic [EXP_LANES-1:0][63:0] t_ff;
   logic signed [54:0]      tpw_in;

   // exp2 output
   logic                       ex_valid;
   logic [EXP_LANES-1:0][31:0] ex_val;
   side_type                   ex_side;

   // Numerator stages
   logic        vn1_ff, vn2_ff;
   logic [31:0] srn1_ff;
   logic [32:0] ty_ff;
   logic [47:0] kp_ff;
   logic [16:0] ex_in;
   logic [31:0] pw_in;
   logic [48:0] ty_in;
   logic [63:0] kp_in;
   logic [48:0] sum_in;
   logic [31:0] num_ff, den_ff;

   // Divider and output register
   logic        dv_valid;
   logic [31:0] dv_q;
   logic        dv_bypass;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [31:0] res_in;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= Q_ONE;
         n_ff     <= Q_ONE;
         tau_ff   <= '0;
         cap_ff   <= Q_ONE;
         m_ff     <= Q_ONE;
         floor_ff <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CONSISTENCY_K:       k_ff     <= csr_data;
            REG_FLOW_INDEX_N:        n_ff     <= csr_data;
            REG_YIELD_STRESS:        tau_ff   <= csr_data;
            REG_VISCOSITY_CAP:       cap_ff   <= csr_data;
            REG_REGULARIZATION_RATE: m_ff     <= csr_data;
            REG_STRAIN_RATE_FLOOR:   floor_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage 1: m*sr
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
      if (adv) begin
         sr1_ff    <= req_tdata;
         xprod1_ff <= m_ff * req_tdata;
      end
   end

   // Stage 2: x*log2(e), large x flags exp(-x) as zero
   always_comb begin
      x_in     = xprod1_ff[63:16];
      eprod_in = x_in[20:0] * LOG2E_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         side2_ff.sr  <= sr1_ff;
         side2_ff.e   <= eprod_in[51:14];
         side2_ff.big <= |x_in[47:21];
      end
   end

   ryv_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v2_ff),
      .in_side   (side2_ff),
      .out_valid (lg_valid),
      .out_log   (lg_log),
      .out_side  (lg_side)
   );

   // Exponents: -x*log2(e) and n*log2(sr)
   assign tpw_in = $signed({1'b0, n_ff}) * lg_log;

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else if (adv) begin
         vt_ff <= lg_valid;
      end
      if (adv) begin
         sidet_ff <= lg_side;
         t_ff[0]  <= 64'(-$signed({26'b0, lg_side.e}));
         t_ff[1]  <= 64'(tpw_in);
      end
   end

   ryv_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vt_ff),
      .in_t      (t_ff),
      .in_side   (sidet_ff),
      .out_valid (ex_valid),
      .out_val   (ex_val),
      .out_side  (ex_side)
   );

   // Numerator terms
   always_comb begin
      if (ex_side.big) begin
         ex_in = '0;
      end else if (ex_val[0] > Q_ONE) begin
         ex_in = Q_ONE[16:0];
      end else begin
         ex_in = ex_val[0][16:0];
      end
      if (ex_side.sr == '0) begin
         pw_in = (n_ff == '0) ? Q_ONE : '0;
      end else begin
         pw_in = ex_val[1];
      end
      ty_in = tau_ff * (Q_ONE[16:0] - ex_in);
      kp_in = k_ff * pw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn1_ff <= 1'b0;
      end else if (adv) begin
         vn1_ff <= ex_valid;
      end
      if (adv) begin
         srn1_ff <= ex_side.sr;
         ty_ff   <= ty_in[48:16];
         kp_ff   <= kp_in[63:16];
      end
   end

   // Saturated sum and divisor floor
   assign sum_in = {16'b0, ty_ff} + {1'b0, kp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vn2_ff <= 1'b0;
      end else if (adv) begin
         vn2_ff <= vn1_ff;
      end
      if (adv) begin
         num_ff <= (|sum_in[48:32]) ? MAX32 : sum_in[31:0];
         den_ff <= (srn1_ff > floor_ff) ? srn1_ff : floor_ff;
      end
   end

   ryv_div u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (vn2_ff),
      .in_num     (num_ff),
      .in_den     (den_ff),
      .out_valid  (dv_valid),
      .out_q      (dv_q),
      .out_bypass (dv_bypass)
   );

   // Cap and output register
   assign res_in = (dv_bypass || dv_q >= cap_ff) ? cap_ff : dv_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
      if (adv) begin
         rsp_data_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/ryv_log2.sv */
// Fractional log2 of the strain rate: leading-one normalise, then 16 squaring stages.
module ryv_log2 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  ryv_pkg::side_type                in_side,
   output logic                             out_valid,
   output logic signed [ryv_pkg::LOG_W-1:0] out_log,
   output ryv_pkg::side_type                out_side
);
   import ryv_pkg::*;

   logic [4:0]        lead_in;
   logic [31:0]       y_in;

   logic              valid_ff [0:FRAC_W];
   logic [31:0]       y_ff     [0:FRAC_W];
   logic [FRAC_W-1:0] fr_ff    [0:FRAC_W];
   logic [4:0]        p_ff     [0:FRAC_W];
   side_type          side_ff  [0:FRAC_W];

   // Position of the leading one
   always_comb begin
      lead_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (in_side.sr[i]) lead_in = 5'(i);
      end
      y_in = in_side.sr << (5'd31 - lead_in);
   end

   // Normalise stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         y_ff[0]    <= y_in;
         fr_ff[0]   <= '0;
         p_ff[0]    <= lead_in;
         side_ff[0] <= in_side;
      end
   end

   // One fraction bit per squaring stage
   for (genvar s = 1; s <= FRAC_W; s++) begin : g_sq
      logic [63:0] sq_in;
      logic [32:0] t_in;
      always_comb begin
         sq_in = y_ff[s-1] * y_ff[s-1];
         t_in  = sq_in[63:31];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         if (adv) begin
            y_ff[s]    <= t_in[32] ? t_in[32:1] : t_in[31:0];
            fr_ff[s]   <= {fr_ff[s-1][FRAC_W-2:0], t_in[32]};
            p_ff[s]    <= p_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[FRAC_W];
   assign out_log   = {6'(p_ff[FRAC_W]) - 6'd16, fr_ff[FRAC_W]};
   assign out_side  = side_ff[FRAC_W];

endmodule

/* sv/ryv_exp2.sv */
// Two-lane pipelined exp2 of signed Q.32 exponents, result Q16.16 saturated.
module ryv_exp2 (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         adv,
   input  logic                                         in_valid,
   input  logic [ryv_pkg::EXP_LANES-1:0][63:0]          in_t,
   input  ryv_pkg::side_type                            in_side,
   output logic                                         out_valid,
   output logic [ryv_pkg::EXP_LANES-1:0][31:0]          out_val,
   output ryv_pkg::side_type                            out_side
);
   import ryv_pkg::*;

   logic                                valid_ff [0:FRAC_W];
   side_type                            side_ff  [0:FRAC_W];
   logic [EXP_LANES-1:0][31:0]          mant_ff  [0:FRAC_W];
   logic [EXP_LANES-1:0][FRAC_W-1:0]    frac_ff  [0:FRAC_W];
   logic [EXP_LANES-1:0][7:0]           ip_ff    [0:FRAC_W];
   logic [EXP_LANES-1:0]                lo_ff    [0:FRAC_W];
   logic [EXP_LANES-1:0]                hi_ff    [0:FRAC_W];

   logic [EXP_LANES-1:0][31:0]          res_in;
   logic                                out_valid_ff;
   logic [EXP_LANES-1:0][31:0]          out_val_ff;
   side_type                            out_side_ff;

   // Range split: integer shift and top fraction bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         side_ff[0] <= in_side;
         for (int l = 0; l < EXP_LANES; l++) begin
            lo_ff[0][l]   <= $signed(in_t[l]) < EXP_LO;
            hi_ff[0][l]   <= $signed(in_t[l]) >= EXP_HI;
            ip_ff[0][l]   <= in_t[l][39:32];
            frac_ff[0][l] <= in_t[l][31:16];
            mant_ff[0][l] <= 32'h4000_0000;
         end
      end
   end

   // One factor 2^(2^-s) per stage
   for (genvar s = 1; s <= FRAC_W; s++) begin : g_fac
      logic [EXP_LANES-1:0][31:0] mant_in;
      always_comb begin
         logic [63:0] prod;
         for (int l = 0; l < EXP_LANES; l++) begin
            prod = mant_ff[s-1][l] * EXP2_FAC[(s-1)*32 +: 32];
            mant_in[l] = frac_ff[s-1][l][FRAC_W-s] ? prod[61:30] : mant_ff[s-1][l];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         if (adv) begin
            side_ff[s] <= side_ff[s-1];
            mant_ff[s] <= mant_in;
            frac_ff[s] <= frac_ff[s-1];
            ip_ff[s]   <= ip_ff[s-1];
            lo_ff[s]   <= lo_ff[s-1];
            hi_ff[s]   <= hi_ff[s-1];
         end
      end
   end

   // Final shift and saturation
   always_comb begin
      logic signed [7:0] ip;
      logic [7:0]        sh;
      logic [32:0]       wide;
      for (int l = 0; l < EXP_LANES; l++) begin
         ip   = $signed(ip_ff[FRAC_W][l]);
         sh   = 8'(8'sd14 - ip);
         wide = {1'b0, mant_ff[FRAC_W][l]} << ip[0];
         priority if (lo_ff[FRAC_W][l]) begin
            res_in[l] = '0;
         end else if (hi_ff[FRAC_W][l]) begin
            res_in[l] = MAX32;
         end else if (ip >= 8'sd14) begin
            res_in[l] = wide[32] ? MAX32 : wide[31:0];
         end else if (sh >= 8'd31) begin
            res_in[l] = '0;
         end else begin
            res_in[l] = mant_ff[FRAC_W][l] >> sh[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= valid_ff[FRAC_W];
      end
      if (adv) begin
         out_val_ff  <= res_in;
         out_side_ff <= side_ff[FRAC_W];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_val   = out_val_ff;
   assign out_side  = out_side_ff;

endmodule

/* sv/ryv_div.sv */
// Restoring divider, one quotient bit per stage: floor(num*2^16 / den), with overflow flag.
module ryv_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [31:0] in_num,
   input  logic [31:0] in_den,
   output logic        out_valid,
   output logic [31:0] out_q,
   output logic        out_bypass
);
   import ryv_pkg::*;

   localparam int unsigned STEPS = DATA_W;

   logic        valid_ff  [0:STEPS];
   logic [31:0] rem_ff    [0:STEPS];
   logic [31:0] lo_ff     [0:STEPS];
   logic [31:0] q_ff      [0:STEPS];
   logic [31:0] den_ff    [0:STEPS];
   logic        bypass_ff [0:STEPS];

   // Zero divisor or a quotient above 32 bits both set the bypass flag, which the top level turns into the cap
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         rem_ff[0]    <= {16'b0, in_num[31:16]};
         lo_ff[0]     <= {in_num[15:0], 16'b0};
         q_ff[0]      <= '0;
         den_ff[0]    <= in_den;
         bypass_ff[0] <= (in_den == '0) || ({16'b0, in_num} >= {in_den, 16'b0});
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      logic [32:0] r_in;
      logic [32:0] d_in;
      logic        ge_in;
      always_comb begin
         r_in  = {rem_ff[s-1], lo_ff[s-1][31]};
         ge_in = r_in >= {1'b0, den_ff[s-1]};
         d_in  = r_in - {1'b0, den_ff[s-1]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         if (adv) begin
            rem_ff[s]    <= ge_in ? d_in[31:0] : r_in[31:0];
            lo_ff[s]     <= {lo_ff[s-1][30:0], 1'b0};
            q_ff[s]      <= {q_ff[s-1][30:0], ge_in};
            den_ff[s]    <= den_ff[s-1];
            bypass_ff[s] <= bypass_ff[s-1];
         end
      end
   end

   assign out_valid  = valid_ff[STEPS];
   assign out_q      = q_ff[STEPS];
   assign out_bypass = bypass_ff[STEPS];

endmodule

/* sv/ryv_chk.sv */
// Port-level checks for the viscosity pipeline, bound to the top level.
module ryv_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [ryv_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [31:0] csr_data
);
   import ryv_pkg::*;

   // No result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // A held result blocks new input in the same cycle
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result held");

   // Held result stays and keeps its value
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind regularized_yield_viscosity ryv_chk u_ryv_chk (.*);
